// ----- sv/s2l_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// s2l_pkg
// Types, fixed-point formats, constant divisors and the sRGB decode table
// shared by the sRGB to CIE L*a*b* pipeline.
// ----------------------------------------------------------------------------
package s2l_pkg;

  localparam int FRAC_BITS  = 8;                  // fraction bits of L, a, b
  localparam int Q_FRAC     = 20;                 // internal Q format
  localparam int OUT_SHIFT  = Q_FRAC - FRAC_BITS;

  localparam int LIN_W      = Q_FRAC + 1;         // linear channel, up to 1.0
  localparam int NUM_W      = 38;                 // dividend width
  localparam int HALF_W     = NUM_W / 2;
  localparam int MUL_W      = 25;                 // reciprocal width
  localparam int DIV_W      = 17;                 // divisor width
  localparam int Q_W        = Q_FRAC + 2;         // quotient, ratio and f width
  localparam int DIV_SHIFT  = NUM_W;
  localparam int CDIV_LAT   = 4;
  localparam int CBRT_STEPS = Q_W;
  localparam int LABF_LAT   = CBRT_STEPS;
  localparam int LIN_DELAY  = CBRT_STEPS - 1 - CDIV_LAT;
  localparam int SQ_W       = 2 * Q_W;
  localparam int P_W        = SQ_W - Q_FRAC;
  localparam int PROD_W     = P_W + Q_W;
  localparam int ACC_W      = 33;
  localparam int TOTAL_LAT  = 2 + CDIV_LAT + LABF_LAT + 2;

  localparam logic [DIV_W-1:0] DIV_X  = DIV_W'(95047);
  localparam logic [DIV_W-1:0] DIV_Y  = DIV_W'(10000);
  localparam logic [DIV_W-1:0] DIV_Z  = DIV_W'(108883);
  localparam logic [DIV_W-1:0] DIV_LF = DIV_W'(116000);

  localparam logic [MUL_W-1:0] RECIP_X  = MUL_W'((64'd1 << DIV_SHIFT) / 64'd95047);
  localparam logic [MUL_W-1:0] RECIP_Y  = MUL_W'((64'd1 << DIV_SHIFT) / 64'd10000);
  localparam logic [MUL_W-1:0] RECIP_Z  = MUL_W'((64'd1 << DIV_SHIFT) / 64'd108883);
  localparam logic [MUL_W-1:0] RECIP_LF = MUL_W'((64'd1 << DIV_SHIFT) / 64'd116000);

  // ratio above this takes the cube root branch
  localparam logic [Q_W-1:0] F_THRESH = Q_W'((64'd8856 << Q_FRAC) / 64'd1000000);
  localparam logic [NUM_W-1:0] LF_SLOPE  = NUM_W'(903292);
  localparam logic [NUM_W-1:0] LF_OFFSET = NUM_W'((64'd16000 << Q_FRAC) + 64'd58000);

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } pixel_t;

  typedef struct packed {
    logic        [14:0] lightness;
    logic signed [15:0] green_red_axis;
    logic signed [15:0] blue_yellow_axis;
  } lab_t;

  typedef logic [LIN_W-1:0] lin_table_t [256];

  // gamma decode of one channel code, Q20
  function automatic logic [LIN_W-1:0] lin_value(input int unsigned c);
    logic [63:0] cc;
    logic [63:0] t;
    logic [63:0] t2;
    logic [63:0] r;
    logic [63:0] cand;
    logic [63:0] p;
    cc = 64'(c);
    r  = 64'd0;
    if (cc <= 64'd10) begin
      return LIN_W'((((cc * 64'd10) << Q_FRAC) + 64'd16473) / 64'd32946);
    end
    t  = (((64'd1000 * cc + 64'd14025) << Q_FRAC) + 64'd134512) / 64'd269025;
    t2 = (t * t + (64'd1 << (Q_FRAC - 1))) >> Q_FRAC;
    for (int b = Q_FRAC; b >= 0; b--) begin
      cand = r | (64'd1 << b);
      p = cand;
      for (int k = 0; k < 4; k++) begin
        p = (p * cand) >> Q_FRAC;
      end
      if (cand <= (64'd1 << Q_FRAC) && p <= t2) begin
        r = cand;
      end
    end
    return LIN_W'((t2 * r + (64'd1 << (Q_FRAC - 1))) >> Q_FRAC);
  endfunction

  function automatic lin_table_t build_lin_table();
    lin_table_t tab;
    for (int i = 0; i < 256; i++) begin
      tab[i] = lin_value(i);
    end
    return tab;
  endfunction

  localparam lin_table_t LIN_TABLE = build_lin_table();

endpackage

// ----- sv/s2l_cdiv.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// s2l_cdiv
// Pipelined floor division by a fixed divisor: reciprocal multiply split in
// two partial products, then one remainder check and correction.
// ----------------------------------------------------------------------------
module s2l_cdiv (
  input  logic                         clk,
  input  logic [s2l_pkg::NUM_W-1:0]    num,
  input  logic [s2l_pkg::MUL_W-1:0]    recip,
  input  logic [s2l_pkg::DIV_W-1:0]    divisor,
  output logic [s2l_pkg::Q_W-1:0]      quot
);
  import s2l_pkg::*;

  localparam int PP_W   = HALF_W + MUL_W;
  localparam int FULL_W = NUM_W + MUL_W;
  localparam int DP_W   = Q_W + DIV_W;

  logic [PP_W-1:0]   pp_hi;
  logic [PP_W-1:0]   pp_lo;
  logic [NUM_W-1:0]  num1;
  logic [Q_W-1:0]    q0;
  logic [NUM_W-1:0]  num2;
  logic [DP_W-1:0]   back;
  logic [Q_W-1:0]    q1;
  logic [NUM_W-1:0]  num3;
  logic [FULL_W-1:0] full;
  logic [NUM_W-1:0]  rem;

  assign full = (FULL_W'(pp_hi) << HALF_W) + FULL_W'(pp_lo);
  assign rem  = num3 - NUM_W'(back);

  always_ff @(posedge clk) begin
    pp_hi <= PP_W'(num[NUM_W-1:HALF_W]) * PP_W'(recip);
    pp_lo <= PP_W'(num[HALF_W-1:0]) * PP_W'(recip);
    num1  <= num;
    q0    <= Q_W'(full >> DIV_SHIFT);
    num2  <= num1;
    back  <= DP_W'(q0) * DP_W'(divisor);
    q1    <= q0;
    num3  <= num2;
    // estimate is low by at most one
    quot  <= (rem >= NUM_W'(divisor)) ? q1 + Q_W'(1) : q1;
  end

endmodule

// ----- sv/s2l_labf.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// s2l_labf
// CIE f(t) of one normalized ratio: a bit-per-stage cube root pipeline with
// the linear segment computed alongside and selected at the end.
// ----------------------------------------------------------------------------
module s2l_labf (
  input  logic                    clk,
  input  logic [s2l_pkg::Q_W-1:0] ratio,
  output logic [s2l_pkg::Q_W-1:0] f
);
  import s2l_pkg::*;

  logic [Q_W-1:0]   root  [CBRT_STEPS+1];
  logic [SQ_W-1:0]  sq    [CBRT_STEPS+1];
  logic [Q_W-1:0]   rat   [CBRT_STEPS+1];
  logic             cube  [CBRT_STEPS+1];
  logic [NUM_W-1:0] lf_num;
  logic [Q_W-1:0]   lf_quot;
  logic [Q_W-1:0]   lf_dly [LIN_DELAY];

  assign root[0] = '0;
  assign sq[0]   = '0;
  assign rat[0]  = ratio;
  assign cube[0] = ratio > F_THRESH;

  for (genvar i = 0; i < CBRT_STEPS; i++) begin : g_step
    localparam int B = CBRT_STEPS - 1 - i;
    logic [Q_W-1:0]    cand;
    logic [SQ_W-1:0]   cand_sq;
    logic [PROD_W-1:0] prod;
    logic              take;

    // square grows by shift and add, exact
    always_comb begin
      cand    = root[i] | (Q_W'(1) << B);
      cand_sq = sq[i] + (SQ_W'(root[i]) << (B + 1)) + (SQ_W'(1) << (2 * B));
      prod    = PROD_W'(cand_sq[SQ_W-1:Q_FRAC]) * PROD_W'(cand);
      take    = prod[PROD_W-1:Q_FRAC] <= (PROD_W - Q_FRAC)'(rat[i]);
    end

    always_ff @(posedge clk) begin
      root[i+1] <= take ? cand : root[i];
      sq[i+1]   <= take ? cand_sq : sq[i];
      rat[i+1]  <= rat[i];
      cube[i+1] <= cube[i];
    end
  end

  // linear segment
  always_ff @(posedge clk) begin
    lf_num <= LF_SLOPE * NUM_W'(ratio) + LF_OFFSET;
  end

  s2l_cdiv u_lf_div (
    .clk     (clk),
    .num     (lf_num),
    .recip   (RECIP_LF),
    .divisor (DIV_LF),
    .quot    (lf_quot)
  );

  always_ff @(posedge clk) begin
    lf_dly[0] <= lf_quot;
    for (int k = 1; k < LIN_DELAY; k++) begin
      lf_dly[k] <= lf_dly[k-1];
    end
  end

  assign f = cube[CBRT_STEPS] ? root[CBRT_STEPS] : lf_dly[LIN_DELAY-1];

endmodule

// ----- sv/srgb_to_cielab_converter.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srgb_to_cielab_converter
// sRGB (8 bits a channel) to CIE L*a*b*, D65 white, 2-degree observer.
// ----------------------------------------------------------------------------
// One pixel word is taken on any cycle start is high; busy is always low, so
// a new pixel may enter every clock. Each result shows on lab for one cycle
// with done high, in the order in which the pixels were taken.
// The depth is set by the 22-stage cube root pipeline (one root bit a stage)
// plus the 4-stage constant dividers, gamma table, matrix and output stages.
// There is no state between pixels and results cannot be held off.
// ----------------------------------------------------------------------------
module srgb_to_cielab_converter (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  output logic            busy,
  input  s2l_pkg::pixel_t pixel,
  output logic            done,
  output s2l_pkg::lab_t   lab
);
  import s2l_pkg::*;

  logic [TOTAL_LAT-1:0] vld;
  logic [LIN_W-1:0]     lin_r;
  logic [LIN_W-1:0]     lin_g;
  logic [LIN_W-1:0]     lin_b;
  logic [NUM_W-1:0]     num_x;
  logic [NUM_W-1:0]     num_y;
  logic [NUM_W-1:0]     num_z;
  logic [Q_W-1:0]       rat_x;
  logic [Q_W-1:0]       rat_y;
  logic [Q_W-1:0]       rat_z;
  logic [Q_W-1:0]       fx;
  logic [Q_W-1:0]       fy;
  logic [Q_W-1:0]       fz;
  logic signed [ACC_W-1:0] l_acc;
  logic signed [ACC_W-1:0] a_acc;
  logic signed [ACC_W-1:0] b_acc;
  logic signed [ACC_W-1:0] l_out;
  logic signed [ACC_W-1:0] a_out;
  logic signed [ACC_W-1:0] b_out;

  function automatic logic signed [ACC_W-1:0] round_sat(
    input logic signed [ACC_W-1:0] v,
    input logic signed [ACC_W-1:0] lo,
    input logic signed [ACC_W-1:0] hi
  );
    logic [ACC_W-1:0]        mag;
    logic [ACC_W-1:0]        q;
    logic signed [ACC_W-1:0] res;
    mag = v[ACC_W-1] ? ACC_W'(-v) : ACC_W'(v);
    q   = (mag + (ACC_W'(1) << (OUT_SHIFT - 1))) >> OUT_SHIFT;
    res = v[ACC_W-1] ? -$signed(q) : $signed(q);
    if (res < lo) begin
      res = lo;
    end
    if (res > hi) begin
      res = hi;
    end
    return res;
  endfunction

  assign busy = 1'b0;
  assign done = vld[TOTAL_LAT-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[TOTAL_LAT-2:0], start & ~busy};
    end
  end

  // gamma decode, then matrix folded with the white point rounding offsets
  always_ff @(posedge clk) begin
    lin_r <= LIN_TABLE[pixel.red];
    lin_g <= LIN_TABLE[pixel.green];
    lin_b <= LIN_TABLE[pixel.blue];
    num_x <= NUM_W'(41240) * NUM_W'(lin_r) + NUM_W'(35760) * NUM_W'(lin_g)
           + NUM_W'(18050) * NUM_W'(lin_b) + NUM_W'(47523);
    num_y <= NUM_W'(2126) * NUM_W'(lin_r) + NUM_W'(7152) * NUM_W'(lin_g)
           + NUM_W'(722) * NUM_W'(lin_b) + NUM_W'(5000);
    num_z <= NUM_W'(1930) * NUM_W'(lin_r) + NUM_W'(11920) * NUM_W'(lin_g)
           + NUM_W'(95050) * NUM_W'(lin_b) + NUM_W'(54441);
  end

  s2l_cdiv u_div_x (.clk(clk), .num(num_x), .recip(RECIP_X), .divisor(DIV_X), .quot(rat_x));
  s2l_cdiv u_div_y (.clk(clk), .num(num_y), .recip(RECIP_Y), .divisor(DIV_Y), .quot(rat_y));
  s2l_cdiv u_div_z (.clk(clk), .num(num_z), .recip(RECIP_Z), .divisor(DIV_Z), .quot(rat_z));

  s2l_labf u_f_x (.clk(clk), .ratio(rat_x), .f(fx));
  s2l_labf u_f_y (.clk(clk), .ratio(rat_y), .f(fy));
  s2l_labf u_f_z (.clk(clk), .ratio(rat_z), .f(fz));

  always_ff @(posedge clk) begin
    l_acc <= $signed(ACC_W'(116)) * $signed(ACC_W'(fy))
           - $signed(ACC_W'(16) << Q_FRAC);
    a_acc <= $signed(ACC_W'(500)) * ($signed(ACC_W'(fx)) - $signed(ACC_W'(fy)));
    b_acc <= $signed(ACC_W'(200)) * ($signed(ACC_W'(fy)) - $signed(ACC_W'(fz)));
  end

  assign l_out = round_sat(l_acc, ACC_W'(0), ACC_W'(32767));
  assign a_out = round_sat(a_acc, -$signed(ACC_W'(32768)), ACC_W'(32767));
  assign b_out = round_sat(b_acc, -$signed(ACC_W'(32768)), ACC_W'(32767));

  always_ff @(posedge clk) begin
    lab.lightness        <= l_out[14:0];
    lab.green_red_axis   <= a_out[15:0];
    lab.blue_yellow_axis <= b_out[15:0];
  end

endmodule
